// ----- design/bhsw_pkg.sv -----
// Shared constants, register codes and tap-order helpers for the stencil weights unit.
`default_nettype none
package bhsw_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int POS_W         = 28;
    localparam int XCFG_W        = 12;
    localparam int ZCFG_W        = 13;
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int TAP_W         = 4;
    localparam int XIDX_W        = 13;
    localparam int ZIDX_W        = 12;
    localparam int WGT_W         = 20;
    localparam int IN_TDATA_W    = 56;
    localparam int OUT_TDATA_W   = 56;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_X_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_LAST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE  = 2'd2;

    localparam logic [XCFG_W-1:0] X_FIRST_RST = 12'd2;
    localparam logic [XCFG_W-1:0] X_LAST_RST  = 12'd65;
    localparam logic [ZCFG_W-1:0] Z_SIZE_RST  = 13'd64;

    // Weight slot (offset plus one) on the x axis for a tap number.
    function automatic logic [1:0] tap_x_slot(input logic [TAP_W-1:0] k);
        logic [1:0] s;
        case (k[3:2])
            2'd0:    s = 2'd0;
            2'd1:    s = 2'd2;
            2'd2:    s = 2'd3;
            default: s = 2'd1;
        endcase
        return s;
    endfunction

    // Weight slot (offset plus one) on the z axis for a tap number.
    function automatic logic [1:0] tap_z_slot(input logic [TAP_W-1:0] k);
        logic [1:0] s;
        case (k[1:0])
            2'd0:    s = 2'd1;
            2'd1:    s = 2'd0;
            2'd2:    s = 2'd2;
            default: s = 2'd3;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- design/bhsw_queue.sv -----
// Small first-in first-out queue of item descriptors between the front and back parts.
`default_nettype none
module bhsw_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/bhsw_front.sv -----
// Front part: accepts positions, clamps the x corner, reduces z modulo the size, forms axis weights.
`default_nettype none
module bhsw_front #(
    parameter int FRAC_BITS = bhsw_pkg::FRAC_BITS_DEF,
    parameter int DESC_W    = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [bhsw_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [bhsw_pkg::POS_W-1:0] i_pos_z,
    input  wire logic [bhsw_pkg::XCFG_W-1:0]       i_x_first,
    input  wire logic [bhsw_pkg::XCFG_W-1:0]       i_x_last,
    input  wire logic [bhsw_pkg::ZCFG_W-1:0]       i_nz,
    output logic                                   o_push,
    output logic [DESC_W-1:0]                      o_desc,
    input  wire logic                              i_full
);
    import bhsw_pkg::*;

    localparam int CW = POS_W - FRAC_BITS;       // corner width
    localparam int EW = ((CW > XCFG_W) ? CW : XCFG_W) + 2;
    localparam int TW = FRAC_BITS + 1;           // t in [0, ONE]
    localparam int PW = 2 * TW;
    localparam int WW = FRAC_BITS + 4;           // doubled 1-D weight
    localparam int NW = $clog2(CW + 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_PUSH} t_fstate;

    t_fstate                r_state;
    logic [NW-1:0]          r_cnt;
    logic [TW-1:0]          r_tx, r_tz, r_t2x, r_t2z, r_t3x, r_t3z;
    logic [XIDX_W-1:0]      r_ix;
    logic [CW-1:0]          r_mag;
    logic                   r_neg;
    logic [ZCFG_W-1:0]      r_rem;

    logic signed [CW-1:0]   cx, cz;
    logic signed [EW-1:0]   ex, e_last, e_first, ex1;
    logic [TW-1:0]          tx0, tx1;
    logic [PW-1:0]          px, pz;
    logic [ZCFG_W:0]        rem_sh;
    logic [ZCFG_W-1:0]      kzm;
    logic signed [WW-1:0]   wx [4];
    logic signed [WW-1:0]   wz [4];

    function automatic logic [TW-1:0] round_f(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = p + (PW'(1) << (FRAC_BITS - 1));
        return TW'(s >> FRAC_BITS);
    endfunction

    // Doubled weights for offsets -1, 0, 1, 2 from t, t^2 and t^3.
    function automatic void axis_w(input logic [TW-1:0] t, input logic [TW-1:0] t2,
                                   input logic [TW-1:0] t3,
                                   output logic signed [WW-1:0] w0,
                                   output logic signed [WW-1:0] w1,
                                   output logic signed [WW-1:0] w2,
                                   output logic signed [WW-1:0] w3);
        logic signed [WW-1:0] st, st2, st3, one, h00, h01, h10, h11;
        st  = WW'(t);
        st2 = WW'(t2);
        st3 = WW'(t3);
        one = WW'(1) << FRAC_BITS;
        h00 = WW'(2 * st3 - 3 * st2 + one);
        h01 = WW'(3 * st2 - 2 * st3);
        h10 = WW'(st3 - 2 * st2 + st);
        h11 = st3 - st2;
        w0  = -h10;
        w1  = WW'(2 * h00 - h11);
        w2  = WW'(2 * h01 + h10);
        w3  = h11;
    endfunction

    assign o_ready = (r_state == S_IDLE);

    // Corner split and x clamp at acceptance.
    always_comb begin
        cx      = i_pos_x[POS_W-1:FRAC_BITS];
        cz      = i_pos_z[POS_W-1:FRAC_BITS];
        ex      = EW'(cx);
        e_last  = EW'({1'b0, i_x_last});
        e_first = EW'({1'b0, i_x_first});
        tx0     = TW'(i_pos_x[FRAC_BITS-1:0]);
        ex1     = ex;
        tx1     = tx0;
        if (ex >= e_last) begin
            ex1 = e_last - EW'(1);
            tx1 = TW'(1) << FRAC_BITS;
        end
        if (ex1 < e_first) begin
            ex1 = e_first;
            tx1 = '0;
        end
    end

    assign px     = (r_cnt == '0) ? PW'(r_tx) * PW'(r_tx) : PW'(r_t2x) * PW'(r_tx);
    assign pz     = (r_cnt == '0) ? PW'(r_tz) * PW'(r_tz) : PW'(r_t2z) * PW'(r_tz);
    assign rem_sh = {r_rem, r_mag[CW-1]};
    assign kzm    = (r_neg && r_rem != '0) ? i_nz - r_rem : r_rem;

    always_comb begin
        axis_w(r_tx, r_t2x, r_t3x, wx[0], wx[1], wx[2], wx[3]);
        axis_w(r_tz, r_t2z, r_t3z, wz[0], wz[1], wz[2], wz[3]);
    end

    assign o_push = (r_state == S_PUSH) && !i_full;
    assign o_desc = DESC_W'({r_ix, kzm, wx[0], wx[1], wx[2], wx[3],
                             wz[0], wz[1], wz[2], wz[3]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_RUN;
                        r_cnt   <= '0;
                        r_ix    <= ex1[XIDX_W-1:0];
                        r_tx    <= tx1;
                        r_tz    <= TW'(i_pos_z[FRAC_BITS-1:0]);
                        r_neg   <= cz[CW-1];
                        r_mag   <= cz[CW-1] ? CW'(-cz) : CW'(cz);
                        r_rem   <= '0;
                    end
                end
                S_RUN: begin
                    // One remainder bit per cycle; the two multiplies ride along.
                    r_mag <= r_mag << 1;
                    r_rem <= (rem_sh >= {1'b0, i_nz}) ? ZCFG_W'(rem_sh - {1'b0, i_nz})
                                                      : ZCFG_W'(rem_sh);
                    if (r_cnt == '0) begin
                        r_t2x <= round_f(px);
                        r_t2z <= round_f(pz);
                    end
                    if (r_cnt == NW'(1)) begin
                        r_t3x <= round_f(px);
                        r_t3z <= round_f(pz);
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == NW'(CW - 1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/bhsw_back.sv -----
// Back part: walks the sixteen taps of a descriptor and drives the registered result stream.
`default_nettype none
module bhsw_back #(
    parameter int FRAC_BITS = bhsw_pkg::FRAC_BITS_DEF,
    parameter int DESC_W    = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_qvalid,
    input  wire logic [DESC_W-1:0]                  i_desc,
    output logic                                    o_pop,
    input  wire logic [bhsw_pkg::ZCFG_W-1:0]        i_nz,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [bhsw_pkg::OUT_TDATA_W-1:0]        o_data,
    output logic                                    o_last
);
    import bhsw_pkg::*;

    localparam int WW = FRAC_BITS + 4;
    localparam int MW = 2 * WW;
    localparam int SW = ZCFG_W + 2;

    logic                   r_busy;
    logic [TAP_W-1:0]       r_k;
    logic [DESC_W-1:0]      r_desc;
    logic                   r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;
    logic                   r_olast;

    logic                   adv;
    logic [XIDX_W-1:0]      ix;
    logic [ZCFG_W-1:0]      kz;
    logic signed [WW-1:0]   wx [4];
    logic signed [WW-1:0]   wz [4];
    logic [1:0]             xs, zs;
    logic signed [MW-1:0]   prod, rnd;
    logic signed [WGT_W-1:0] wgt;
    logic signed [SW-1:0]   s;
    logic [ZIDX_W-1:0]      zi;
    logic [XIDX_W-1:0]      xi;

    assign {ix, kz, wx[0], wx[1], wx[2], wx[3], wz[0], wz[1], wz[2], wz[3]} = r_desc;

    assign adv   = !r_ovalid || i_ready;
    assign o_pop = i_qvalid && (!r_busy || (adv && r_k == TAP_W'(15)));

    always_comb begin
        xs   = tap_x_slot(r_k);
        zs   = tap_z_slot(r_k);
        xi   = ix + XIDX_W'(xs) - XIDX_W'(1);
        prod = MW'(wx[xs]) * MW'(wz[zs]);
        rnd  = (prod + (MW'(1) <<< (FRAC_BITS + 1))) >>> (FRAC_BITS + 2);
        if (rnd > MW'((1 << (WGT_W - 1)) - 1)) begin
            wgt = {1'b0, {(WGT_W-1){1'b1}}};
        end else if (rnd < -(MW'(1) <<< (WGT_W - 1))) begin
            wgt = {1'b1, {(WGT_W-1){1'b0}}};
        end else begin
            wgt = rnd[WGT_W-1:0];
        end
        s = SW'({1'b0, kz}) + SW'(zs) - SW'(1);
        if (s < 0) begin
            s = s + SW'({1'b0, i_nz});
        end else if (s >= SW'({1'b0, i_nz})) begin
            s = s - SW'({1'b0, i_nz});
        end
        zi = (i_nz == ZCFG_W'(1)) ? '0 : s[ZIDX_W-1:0];
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;

    // The tap counter wraps to zero after the sixteenth tap, so it is already
    // zero whenever a new descriptor is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                r_ovalid <= r_busy;
                if (r_busy) begin
                    r_odata <= OUT_TDATA_W'({wgt, zi, xi, r_k});
                    r_olast <= (r_k == TAP_W'(15));
                    r_k     <= r_k + 1'b1;
                end
            end
            if (o_pop) begin
                r_desc <= i_desc;
                r_busy <= 1'b1;
            end else if (adv && r_busy && r_k == TAP_W'(15)) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/bicubic_hermite_stencil_weights_unit.sv -----
// Top level of the bicubic Hermite stencil weights unit.
`default_nettype none
// One position transaction (x, z, signed fixed point with FRAC_BITS fraction bits) yields
// sixteen result transactions, one per stencil tap, each carrying the tap number, the x and
// z cell indices and the tap weight; the sixteenth carries tlast. Sustained rate is set
// by the single tap multiplier in the back part, one tap a cycle while m_axis_tready does
// not stall the output. The front part's pace is set by its bit-serial z remainder unit,
// and a two-entry descriptor queue lets it take the next position while the back part
// still emits taps. Configuration registers (x_first, x_last, z_size) are written through
// a plain write port; the user must write them while the unit is idle; it does not check.
module bicubic_hermite_stencil_weights_unit #(
    parameter int FRAC_BITS = bhsw_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [bhsw_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [bhsw_pkg::CFG_W-1:0]            i_cfg_data,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // pos_x [27:0], pos_z [55:28]
    input  wire logic [bhsw_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // tap [3:0], x_index [16:4], z_index [28:17], weight [48:29], zero fill above
    output logic [bhsw_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
    output logic                                       m_axis_tlast
);
    import bhsw_pkg::*;

    // Descriptor: clamped x corner, reduced z corner, four x and four z doubled weights.
    localparam int WW     = FRAC_BITS + 4;
    localparam int DESC_W = XIDX_W + ZCFG_W + 8 * WW;

    logic [XCFG_W-1:0] r_x_first;
    logic [XCFG_W-1:0] r_x_last;
    logic [ZCFG_W-1:0] r_z_size;
    logic [ZCFG_W-1:0] nz;

    logic              push, full, pop, qvalid;
    logic [DESC_W-1:0] desc_in, desc_out;

    // A z size of zero behaves as one.
    assign nz = (r_z_size == '0) ? ZCFG_W'(1) : r_z_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_first <= X_FIRST_RST;
            r_x_last  <= X_LAST_RST;
            r_z_size  <= Z_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_FIRST: r_x_first <= i_cfg_data[XCFG_W-1:0];
                REG_X_LAST:  r_x_last  <= i_cfg_data[XCFG_W-1:0];
                REG_Z_SIZE:  r_z_size  <= i_cfg_data[ZCFG_W-1:0];
                default: ;
            endcase
        end
    end

    bhsw_front #(.FRAC_BITS(FRAC_BITS), .DESC_W(DESC_W)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_pos_x   (s_axis_tdata[POS_W-1:0]),
        .i_pos_z   (s_axis_tdata[2*POS_W-1:POS_W]),
        .i_x_first (r_x_first),
        .i_x_last  (r_x_last),
        .i_nz      (nz),
        .o_push    (push),
        .o_desc    (desc_in),
        .i_full    (full)
    );

    bhsw_queue #(.WIDTH(DESC_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (desc_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qvalid),
        .o_data  (desc_out)
    );

    bhsw_back #(.FRAC_BITS(FRAC_BITS), .DESC_W(DESC_W)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (qvalid),
        .i_desc   (desc_out),
        .o_pop    (pop),
        .i_nz     (nz),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );
endmodule
`default_nettype wire
